### src/rlps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlps_pkg
// Shared types, constants and register codes for the RGB LED pulse
// serializer.
// ----------------------------------------------------------------------------
package rlps_pkg;

  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned LATCH_W    = 20;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned BITPOS_W   = 5;

  localparam int unsigned TIMER_WIDTH_DEF = 20;

  // Reset values of the timing registers (10 ns ticks).
  localparam logic [PULSE_W-1:0] SHORT_RST = 16'd30;
  localparam logic [PULSE_W-1:0] LONG_RST  = 16'd109;
  localparam logic [LATCH_W-1:0] LATCH_RST = 20'd35000;

  // Index of the most significant color bit, sent first.
  localparam logic [BITPOS_W-1:0] TOP_BIT = 5'd23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT = 2'd0,
    REG_LONG  = 2'd1,
    REG_LATCH = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  // Classified item as it travels from the front end to the engine.
  typedef struct packed {
    op_t                kind;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] repeat_count;
  } item_t;

  // Queue to engine handshake.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage
`default_nettype wire

### src/rlps_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlps_cmd_if
// Input channel: valid/ready handshake with operation, color and count.
// ----------------------------------------------------------------------------
interface rlps_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [rlps_pkg::COLOR_W-1:0] color;
  logic [rlps_pkg::COUNT_W-1:0] repeat_count;

  modport source (output valid, operation, color, repeat_count, input ready);
  modport sink   (input valid, operation, color, repeat_count, output ready);
endinterface
`default_nettype wire

### src/rlps_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlps_rsp_if
// Result channel: valid/ready handshake with line level and status flags.
// ----------------------------------------------------------------------------
interface rlps_rsp_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic start_accepted;

  modport source (output valid, line_level, busy_res, start_accepted, input ready);
  modport sink   (input valid, line_level, busy_res, start_accepted, output ready);
endinterface
`default_nettype wire

### src/rlps_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlps_front
// Accepts input transactions, classifies them and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
module rlps_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rlps_cmd_if.sink                   cmd,
  output rlps_pkg::queue_head_t      head,
  input  wire logic                  pop
);

  rlps_pkg::item_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  rlps_pkg::item_t incoming;

  assign cmd.ready = (count != 2'd2);
  assign push      = cmd.valid && cmd.ready;

  always_comb begin
    incoming.kind         = cmd.operation ? rlps_pkg::OP_START : rlps_pkg::OP_TICK;
    incoming.color        = cmd.color;
    incoming.repeat_count = cmd.repeat_count;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // valid flag in front of the oldest queued item
  assign head = {(count != 2'd0), mem[rd_ptr]};

endmodule
`default_nettype wire

### src/rlps_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlps_engine
// Executes one queued item per cycle when the result register is free:
// bit/latch sequencer, pulse timer, timing registers and the result register.
// ----------------------------------------------------------------------------
module rlps_engine #(
  parameter int unsigned TIMER_WIDTH = rlps_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rlps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rlps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire rlps_pkg::queue_head_t            head,
  output logic                                  pop,
  rlps_rsp_if.source                            rsp
);

  localparam logic [31:0] TMAX = 32'hFFFF_FFFF >> (32 - TIMER_WIDTH);

  // Timing registers
  logic [rlps_pkg::PULSE_W-1:0] short_ticks;
  logic [rlps_pkg::PULSE_W-1:0] long_ticks;
  logic [rlps_pkg::LATCH_W-1:0] latch_ticks;

  // Sequencer state
  rlps_pkg::phase_t              phase, phase_next;
  logic [rlps_pkg::COLOR_W-1:0]  color_shift, color_shift_next;
  logic [rlps_pkg::COLOR_W-1:0]  saved_color, saved_color_next;
  logic [rlps_pkg::BITPOS_W-1:0] bit_position, bit_position_next;
  logic [rlps_pkg::COUNT_W-1:0]  copies_left, copies_left_next;
  logic [TIMER_WIDTH-1:0]        tick_timer, tick_timer_next;
  logic                          accepted;

  // Result register
  logic out_valid;
  logic out_line, out_line_next;
  logic out_busy, out_busy_next;
  logic out_acc;

  logic [TIMER_WIDTH-1:0] t_dec;

  function automatic logic [TIMER_WIDTH-1:0] load_count(
    input logic [rlps_pkg::LATCH_W-1:0] v
  );
    logic [31:0] x;
    x = {{(32 - rlps_pkg::LATCH_W){1'b0}}, v};
    if (x == 32'd0) x = 32'd1;
    if (x > TMAX) x = TMAX;
    return x[TIMER_WIDTH-1:0];
  endfunction

  function automatic logic [rlps_pkg::LATCH_W-1:0] widen(
    input logic [rlps_pkg::PULSE_W-1:0] v
  );
    return {{(rlps_pkg::LATCH_W - rlps_pkg::PULSE_W){1'b0}}, v};
  endfunction

  assign pop = head.valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= rlps_pkg::SHORT_RST;
      long_ticks  <= rlps_pkg::LONG_RST;
      latch_ticks <= rlps_pkg::LATCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rlps_pkg::REG_SHORT: short_ticks <= cfg_data[rlps_pkg::PULSE_W-1:0];
        rlps_pkg::REG_LONG:  long_ticks  <= cfg_data[rlps_pkg::PULSE_W-1:0];
        rlps_pkg::REG_LATCH: latch_ticks <= cfg_data[rlps_pkg::LATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_next        = phase;
    color_shift_next  = color_shift;
    saved_color_next  = saved_color;
    bit_position_next = bit_position;
    copies_left_next  = copies_left;
    tick_timer_next   = tick_timer;
    accepted          = 1'b0;
    t_dec             = tick_timer;

    if (pop) begin
      if (head.item.kind == rlps_pkg::OP_START) begin
        if (phase == rlps_pkg::PH_IDLE) begin
          accepted         = 1'b1;
          saved_color_next = head.item.color;
          color_shift_next = head.item.color;
          copies_left_next = head.item.repeat_count;
          if (head.item.repeat_count != '0) begin
            bit_position_next = rlps_pkg::TOP_BIT;
            phase_next        = rlps_pkg::PH_HIGH;
            tick_timer_next   = load_count(head.item.color[rlps_pkg::COLOR_W-1] ?
                                           widen(long_ticks) : widen(short_ticks));
          end else begin
            bit_position_next = '0;
            phase_next        = rlps_pkg::PH_LATCH;
            tick_timer_next   = load_count(latch_ticks);
          end
        end
      end else if (phase != rlps_pkg::PH_IDLE) begin
        if (tick_timer != '0) t_dec = tick_timer - 1'b1;
        tick_timer_next = t_dec;
        if (t_dec == '0) begin
          case (phase)
            rlps_pkg::PH_HIGH: begin
              phase_next      = rlps_pkg::PH_LOW;
              tick_timer_next = load_count(color_shift[rlps_pkg::COLOR_W-1] ?
                                           widen(short_ticks) : widen(long_ticks));
            end
            rlps_pkg::PH_LOW: begin
              if (bit_position != '0) begin
                bit_position_next = bit_position - 1'b1;
                color_shift_next  = {color_shift[rlps_pkg::COLOR_W-2:0], 1'b0};
                phase_next        = rlps_pkg::PH_HIGH;
                tick_timer_next   = load_count(color_shift[rlps_pkg::COLOR_W-2] ?
                                               widen(long_ticks) : widen(short_ticks));
              end else if (copies_left > 8'd1) begin
                copies_left_next  = copies_left - 1'b1;
                color_shift_next  = saved_color;
                bit_position_next = rlps_pkg::TOP_BIT;
                phase_next        = rlps_pkg::PH_HIGH;
                tick_timer_next   = load_count(saved_color[rlps_pkg::COLOR_W-1] ?
                                               widen(long_ticks) : widen(short_ticks));
              end else begin
                copies_left_next = '0;
                color_shift_next = {color_shift[rlps_pkg::COLOR_W-2:0], 1'b0};
                phase_next       = rlps_pkg::PH_LATCH;
                tick_timer_next  = load_count(latch_ticks);
              end
            end
            rlps_pkg::PH_LATCH: begin
              phase_next      = rlps_pkg::PH_IDLE;
              tick_timer_next = '0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Outputs follow the phase after this item
  always_comb begin
    out_line_next = (phase_next == rlps_pkg::PH_HIGH);
    out_busy_next = (phase_next != rlps_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= rlps_pkg::PH_IDLE;
      color_shift  <= '0;
      saved_color  <= '0;
      bit_position <= '0;
      copies_left  <= '0;
      tick_timer   <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      color_shift  <= color_shift_next;
      saved_color  <= saved_color_next;
      bit_position <= bit_position_next;
      copies_left  <= copies_left_next;
      tick_timer   <= tick_timer_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_line <= out_line_next;
      out_busy <= out_busy_next;
      out_acc  <= accepted;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.line_level     = out_line;
  assign rsp.busy_res       = out_busy;
  assign rsp.start_accepted = out_acc;

endmodule
`default_nettype wire

### src/rgb_led_pulse_serializer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_pulse_serializer_top
// One-wire addressable LED line driver: front-end queue plus pulse engine.
// ----------------------------------------------------------------------------
// Each result passes the front-end queue, then the engine's result register.
// Throughput: one transaction per cycle while results drain; the engine retires
//   one queued item per clock whenever its result register is free or drained.
// Reset (rst, synchronous, active high): queue empty, engine idle,
//   timing registers back to 30 / 109 / 35000 ticks.
// ----------------------------------------------------------------------------
module rgb_led_pulse_serializer_top #(
  parameter int unsigned TIMER_WIDTH = rlps_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port: index 0 short, 1 long, 2 latch ticks
  input  wire logic                             cfg_we,
  input  wire logic [rlps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rlps_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Item and result channels
  rlps_cmd_if.sink                              cmd,
  rlps_rsp_if.source                            rsp
);

  // Head of the queue and the pop strobe from the engine
  rlps_pkg::queue_head_t head;
  logic                  pop;

  // Front end: takes a transaction whenever the two-entry queue has room,
  // so it keeps accepting while a result waits in the engine's output.
  rlps_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .head (head),
    .pop  (pop)
  );

  // Engine: one item per cycle whenever the result register is free.
  // Tick items decrement the pulse timer; a part that runs out hands over
  // to the next high/low part, the next copy, or the latch period.
  rlps_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
